/* rtl/kernel_excursion_asid_owner_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the kernel excursion ASID owner filter
// Each macro checks an implication on the rising edge of the given clock,
// disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef KERNEL_EXCURSION_ASID_OWNER_MACROS_SVH
`define KERNEL_EXCURSION_ASID_OWNER_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication.
`define KEAO_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("keao assertion failed");

// Next-cycle implication.
`define KEAO_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("keao assertion failed");

`else

`define KEAO_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define KEAO_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

/* rtl/keao_pkg.sv */
// ----------------------------------------------------------------------------
// keao_pkg
// Shared types and constants of the kernel excursion ASID owner filter.
// ----------------------------------------------------------------------------
`default_nettype none

package keao_pkg;

    localparam int ASID_W      = 16;
    localparam int STORE_DEPTH = 8;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int THR_W       = 6;

    localparam logic [CNT_W-1:0] STORE_FULL      = CNT_W'(STORE_DEPTH);
    localparam logic [THR_W-1:0] STORM_THRESHOLD = THR_W'(8);

    typedef enum logic [1:0] {
        CMD_SEG_OPEN = 2'd0,
        CMD_USER     = 2'd1,
        CMD_KERNEL   = 2'd2,
        CMD_ASID_WR  = 2'd3
    } cmd_t;

    // Scan request toward the shared compare unit.
    typedef struct packed {
        logic              start;
        logic [ASID_W-1:0] value;
        logic [CNT_W-1:0]  count;
    } scan_req_t;

    // Scan answer: done pulses for one cycle, hit tells a match was found.
    typedef struct packed {
        logic done;
        logic hit;
    } scan_rsp_t;

    // Store write port.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [ASID_W-1:0] data;
    } store_wr_t;

endpackage

`default_nettype wire

/* rtl/keao_scan.sv */
// ----------------------------------------------------------------------------
// keao_scan
// Distinct-value store with one shared comparator, walked one entry at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module keao_scan
    import keao_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire scan_req_t req,
    input  wire store_wr_t wr,
    output scan_rsp_t      rsp
);

    typedef enum logic [1:0] {
        SC_IDLE,
        SC_RD,
        SC_CMP
    } sc_state_t;

    sc_state_t         state_reg;
    logic [ADDR_W-1:0] idx_reg;
    logic [ASID_W-1:0] rd_data_reg;
    logic [ASID_W-1:0] store_mem [STORE_DEPTH];
    scan_rsp_t         rsp_reg;

    // Store: one write port, one registered read port addressed by the walker.
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            store_mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= store_mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SC_IDLE;
            idx_reg   <= '0;
            rsp_reg   <= '0;
        end else begin
            rsp_reg <= '0;
            unique case (state_reg)
                SC_IDLE: begin
                    if (req.start) begin
                        idx_reg <= '0;
                        if (req.count == '0) begin
                            rsp_reg <= '{done: 1'b1, hit: 1'b0};
                        end else begin
                            state_reg <= SC_RD;
                        end
                    end
                end
                SC_RD: begin
                    // wait for the registered read
                    state_reg <= SC_CMP;
                end
                SC_CMP: begin
                    if (rd_data_reg == req.value) begin
                        rsp_reg   <= '{done: 1'b1, hit: 1'b1};
                        state_reg <= SC_IDLE;
                    end else if (({1'b0, idx_reg} + CNT_W'(1)) == req.count) begin
                        rsp_reg   <= '{done: 1'b1, hit: 1'b0};
                        state_reg <= SC_IDLE;
                    end else begin
                        idx_reg   <= idx_reg + ADDR_W'(1);
                        state_reg <= SC_RD;
                    end
                end
                default: begin
                    state_reg <= SC_IDLE;
                end
            endcase
        end
    end

    assign rsp = rsp_reg;

endmodule

`default_nettype wire

/* rtl/kernel_excursion_asid_owner.sv */
// ----------------------------------------------------------------------------
// kernel_excursion_asid_owner
// Trace filter deciding whether kernel blocks belong to the pinned ASID.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one transaction per trace event (s_cmd: segment open, user
//   block, kernel block, ASID write; s_asid_value: live or written ASID).
//   m_ channel: exactly one result transaction per event (keep, storm_now,
//   cut_flag, in_excursion).
//   cfg_ channel: writes the traced-process ASID; always ready, write only
//   while idle.
//   Segment open, user block, kernel block and ASID writes that are not
//   counted go through ST_DONE, which raises m_valid once the output
//   register is free. A counted ASID write first walks the distinct-value
//   store through one shared comparator, one stored entry at a time, for N
//   stored values (N up to 7, as the eighth value raises storm and ends
//   counting); a match ends the walk early.
//   One event at a time: s_ready is high only while idle, so a new event
//   is accepted only after the previous one has left ST_DONE.
//   The result register decouples the sides: a new event is accepted while
//   a result still waits; that event finishes once the result is taken.
//   Reset (aresetn low, synchronous) clears all excursion and owner state
//   and the traced ASID; the store contents need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

`include "kernel_excursion_asid_owner_macros.svh"

module kernel_excursion_asid_owner
    import keao_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // configuration write
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [ASID_W-1:0] cfg_wdata,
    // event input
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        s_cmd,
    input  wire logic [ASID_W-1:0] s_asid_value,
    // result output
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic                   m_keep,
    output logic                   m_storm_now,
    output logic                   m_cut_flag,
    output logic                   m_in_excursion
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t            state_reg;

    // filter state
    logic [ASID_W-1:0] traced_asid_reg;
    logic              excursion_open_reg;
    logic              overlay_valid_reg;
    logic [ASID_W-1:0] overlay_asid_reg;
    logic              cut_seen_reg;
    logic [CNT_W-1:0]  distinct_count_reg;
    logic              storm_seen_reg;
    logic [ASID_W-1:0] entry_asid_reg;
    logic              owner_valid_reg;
    logic [ASID_W-1:0] last_user_asid_reg;

    // pending result and output register
    logic              keep_res_reg;
    logic              storm_res_reg;
    logic              m_valid_reg;
    logic              m_keep_reg;
    logic              m_storm_now_reg;
    logic              m_cut_flag_reg;
    logic              m_in_excursion_reg;

    // shared compare unit control
    logic              scan_start_reg;
    logic [ASID_W-1:0] value_reg;
    store_wr_t         store_wr_reg;
    scan_req_t         scan_req;
    scan_rsp_t         scan_rsp;

    cmd_t              cmd;
    logic [CNT_W-1:0]  count_inc;
    logic              s_accept;

    assign cmd       = cmd_t'(s_cmd);
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign count_inc = distinct_count_reg + CNT_W'(1);

    assign scan_req = '{start: scan_start_reg, value: value_reg, count: distinct_count_reg};

    keao_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (scan_req),
        .wr      (store_wr_reg),
        .rsp     (scan_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            traced_asid_reg    <= '0;
            excursion_open_reg <= 1'b0;
            overlay_valid_reg  <= 1'b0;
            overlay_asid_reg   <= '0;
            cut_seen_reg       <= 1'b0;
            distinct_count_reg <= '0;
            storm_seen_reg     <= 1'b0;
            entry_asid_reg     <= '0;
            owner_valid_reg    <= 1'b0;
            last_user_asid_reg <= '0;
            keep_res_reg       <= 1'b0;
            storm_res_reg      <= 1'b0;
            m_valid_reg        <= 1'b0;
            scan_start_reg     <= 1'b0;
            store_wr_reg       <= '0;
        end else begin
            scan_start_reg  <= 1'b0;
            store_wr_reg.en <= 1'b0;

            if (cfg_valid && cfg_ready) begin
                traced_asid_reg <= cfg_wdata;
            end

            // drop the result once the receiver takes it; ST_DONE reloads it
            if (m_valid_reg && m_ready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        keep_res_reg  <= 1'b0;
                        storm_res_reg <= 1'b0;
                        value_reg     <= s_asid_value;
                        state_reg     <= ST_DONE;
                        unique case (cmd)
                            CMD_SEG_OPEN: begin
                                // clear excursion, owner and last user ASID
                                excursion_open_reg <= 1'b0;
                                overlay_valid_reg  <= 1'b0;
                                overlay_asid_reg   <= '0;
                                cut_seen_reg       <= 1'b0;
                                distinct_count_reg <= '0;
                                storm_seen_reg     <= 1'b0;
                                entry_asid_reg     <= '0;
                                owner_valid_reg    <= 1'b0;
                                last_user_asid_reg <= '0;
                            end
                            CMD_USER: begin
                                // close any excursion and record the owner
                                excursion_open_reg <= 1'b0;
                                overlay_valid_reg  <= 1'b0;
                                overlay_asid_reg   <= '0;
                                cut_seen_reg       <= 1'b0;
                                distinct_count_reg <= '0;
                                storm_seen_reg     <= 1'b0;
                                last_user_asid_reg <= s_asid_value;
                                owner_valid_reg    <= 1'b1;
                            end
                            CMD_KERNEL: begin
                                if (!excursion_open_reg) begin
                                    // open a fresh excursion from the last user ASID
                                    excursion_open_reg <= 1'b1;
                                    overlay_valid_reg  <= 1'b0;
                                    overlay_asid_reg   <= '0;
                                    cut_seen_reg       <= 1'b0;
                                    distinct_count_reg <= '0;
                                    storm_seen_reg     <= 1'b0;
                                    entry_asid_reg     <= last_user_asid_reg;
                                    keep_res_reg       <= owner_valid_reg &&
                                        (last_user_asid_reg == traced_asid_reg);
                                end else begin
                                    keep_res_reg <= owner_valid_reg &&
                                        (entry_asid_reg == traced_asid_reg) &&
                                        !cut_seen_reg;
                                end
                            end
                            CMD_ASID_WR: begin
                                if (excursion_open_reg) begin
                                    // restore, overlay or cut
                                    if (s_asid_value != entry_asid_reg) begin
                                        if (!overlay_valid_reg) begin
                                            overlay_valid_reg <= 1'b1;
                                            overlay_asid_reg  <= s_asid_value;
                                        end else if (s_asid_value != overlay_asid_reg) begin
                                            cut_seen_reg <= 1'b1;
                                        end
                                    end
                                    // count distinct values until the storm is raised
                                    if (!storm_seen_reg) begin
                                        scan_start_reg <= 1'b1;
                                        state_reg      <= ST_SCAN;
                                    end
                                end
                            end
                            default: begin
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (scan_rsp.done) begin
                        if (!scan_rsp.hit && (distinct_count_reg < STORE_FULL)) begin
                            store_wr_reg.en    <= 1'b1;
                            store_wr_reg.addr  <= distinct_count_reg[ADDR_W-1:0];
                            store_wr_reg.data  <= value_reg;
                            distinct_count_reg <= count_inc;
                            if ({{(THR_W-CNT_W){1'b0}}, count_inc} >= STORM_THRESHOLD) begin
                                storm_seen_reg <= 1'b1;
                                storm_res_reg  <= 1'b1;
                            end
                        end
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    // hold the result until the output register is free
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg        <= 1'b1;
                        m_keep_reg         <= keep_res_reg;
                        m_storm_now_reg    <= storm_res_reg;
                        m_cut_flag_reg     <= cut_seen_reg;
                        m_in_excursion_reg <= excursion_open_reg;
                        state_reg          <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_keep         = m_keep_reg;
    assign m_storm_now    = m_storm_now_reg;
    assign m_cut_flag     = m_cut_flag_reg;
    assign m_in_excursion = m_in_excursion_reg;

    // One event at a time: an accepted transaction blocks the next cycle.
    `KEAO_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_valid && s_ready, !s_ready)
    // The distinct count never passes the store depth.
    `KEAO_ASSERT_IMPL(a_count_bound, aclk, aresetn, 1'b1, distinct_count_reg <= STORE_FULL)
    // Storm and cut belong to an open excursion.
    `KEAO_ASSERT_IMPL(a_storm_in_exc, aclk, aresetn, storm_seen_reg, excursion_open_reg)
    `KEAO_ASSERT_IMPL(a_cut_after_overlay, aclk, aresetn, cut_seen_reg, overlay_valid_reg)
    // A store write only follows a scan that missed.
    `KEAO_ASSERT_NEXT(a_write_after_miss, aclk, aresetn,
                      scan_rsp.done && scan_rsp.hit, !store_wr_reg.en)

endmodule

`default_nettype wire
